@@ sv/residual_cubic_root_sieve_mod_p_macros.svh @@
// Assertion macros for the residual cubic root sieve.
// Used by the port checker; depends on nothing else.
`ifndef RESIDUAL_CUBIC_ROOT_SIEVE_MOD_P_MACROS_SVH
`define RESIDUAL_CUBIC_ROOT_SIEVE_MOD_P_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCRS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcrs assertion failed");

// Next-cycle implication, disabled during reset.
`define RCRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcrs assertion failed");

`endif

@@ sv/rcrs_pkg.sv @@
// Package for the residual cubic root sieve: widths, opcodes, register file
// addresses and the microcode program. Depends on nothing.
`timescale 1ns / 1ps
package rcrs_pkg;

   localparam int MODULUS_BITS = 10;
   localparam int HEIGHT_BITS  = 16;
   localparam int PC_BITS      = 7;
   localparam int RA_BITS      = 5;
   localparam int CNT_BITS     = 4;

   localparam logic [3:0] OP_RED   = 4'd0;
   localparam logic [3:0] OP_MUL   = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_SUB   = 4'd3;
   localparam logic [3:0] OP_INV   = 4'd4;
   localparam logic [3:0] OP_CHKZ  = 4'd5;
   localparam logic [3:0] OP_CHKEQ = 4'd6;
   localparam logic [3:0] OP_SCAN  = 4'd7;
   localparam logic [3:0] OP_END   = 4'd8;

   localparam logic [2:0] SRC_N1  = 3'd0;
   localparam logic [2:0] SRC_D1  = 3'd1;
   localparam logic [2:0] SRC_N2  = 3'd2;
   localparam logic [2:0] SRC_D2  = 3'd3;
   localparam logic [2:0] SRC_IMM = 3'd4;

   localparam logic [RA_BITS-1:0] FLG_ROOT = 5'd0;
   localparam logic [RA_BITS-1:0] FLG_SQ   = 5'd1;

   localparam logic [RA_BITS-1:0] R_ZERO = 5'd0;
   localparam logic [RA_BITS-1:0] R_ONE  = 5'd1;
   localparam logic [RA_BITS-1:0] R_HALF = 5'd2;
   localparam logic [RA_BITS-1:0] R_U    = 5'd3;
   localparam logic [RA_BITS-1:0] R_W    = 5'd4;
   localparam logic [RA_BITS-1:0] R_UP   = 5'd5;
   localparam logic [RA_BITS-1:0] R_WP   = 5'd6;
   localparam logic [RA_BITS-1:0] R_U2   = 5'd7;
   localparam logic [RA_BITS-1:0] R_W2   = 5'd8;
   localparam logic [RA_BITS-1:0] R_T0   = 5'd9;
   localparam logic [RA_BITS-1:0] R_T1   = 5'd10;
   localparam logic [RA_BITS-1:0] R_T2   = 5'd11;
   localparam logic [RA_BITS-1:0] R_G1   = 5'd12;
   localparam logic [RA_BITS-1:0] R_G2   = 5'd13;
   localparam logic [RA_BITS-1:0] R_K4   = 5'd14;
   localparam logic [RA_BITS-1:0] R_K0   = 5'd15;
   localparam logic [RA_BITS-1:0] R_Q3   = 5'd16;
   localparam logic [RA_BITS-1:0] R_Q2   = 5'd17;
   localparam logic [RA_BITS-1:0] R_S1   = 5'd18;
   localparam logic [RA_BITS-1:0] R_S2   = 5'd19;
   localparam logic [RA_BITS-1:0] R_CA   = 5'd20;
   localparam logic [RA_BITS-1:0] R_CB   = 5'd21;
   localparam logic [RA_BITS-1:0] R_CC   = 5'd22;
   localparam logic [RA_BITS-1:0] R_D    = 5'd23;
   localparam logic [RA_BITS-1:0] R_T3   = 5'd24;
   localparam logic [RA_BITS-1:0] R_V    = 5'd31;

   localparam logic [PC_BITS-1:0] PC_ROOT_LOOP = 7'd57;
   localparam logic [PC_BITS-1:0] PC_SQ_LOOP   = 7'd83;

   typedef struct packed {
      logic [3:0]         opc;
      logic [RA_BITS-1:0] dst;
      logic [RA_BITS-1:0] sa;
      logic [RA_BITS-1:0] sb;
      logic [2:0]         src;
      logic [4:0]         imm;
      logic [PC_BITS-1:0] tgt;
   } instr_type;

   function automatic instr_type i_op(input logic [3:0] opc, input logic [RA_BITS-1:0] d,
                                      input logic [RA_BITS-1:0] a,
                                      input logic [RA_BITS-1:0] b);
      instr_type r;
      r     = '0;
      r.opc = opc;
      r.dst = d;
      r.sa  = a;
      r.sb  = b;
      return r;
   endfunction

   function automatic instr_type i_red(input logic [RA_BITS-1:0] d, input logic [2:0] src,
                                       input logic [4:0] imm);
      instr_type r;
      r     = '0;
      r.opc = OP_RED;
      r.dst = d;
      r.src = src;
      r.imm = imm;
      return r;
   endfunction

   function automatic instr_type i_scan(input logic [RA_BITS-1:0] flg,
                                        input logic [RA_BITS-1:0] a,
                                        input logic [RA_BITS-1:0] b,
                                        input logic [PC_BITS-1:0] tgt);
      instr_type r;
      r     = i_op(OP_SCAN, flg, a, b);
      r.tgt = tgt;
      return r;
   endfunction

   function automatic instr_type ucode(input logic [PC_BITS-1:0] pc);
      instr_type r;
      case (pc)
         7'd0:  r = i_red(R_ZERO, SRC_IMM, 5'd0);
         7'd1:  r = i_red(R_ONE, SRC_IMM, 5'd1);
         7'd2:  r = i_red(R_T0, SRC_D1, 5'd0);
         7'd3:  r = i_op(OP_CHKZ, R_ZERO, R_T0, R_ZERO);
         7'd4:  r = i_red(R_T1, SRC_D2, 5'd0);
         7'd5:  r = i_op(OP_CHKZ, R_ZERO, R_T1, R_ZERO);
         7'd6:  r = i_op(OP_INV, R_T0, R_T0, R_ZERO);
         7'd7:  r = i_red(R_T2, SRC_N1, 5'd0);
         7'd8:  r = i_op(OP_MUL, R_U, R_T2, R_T0);
         7'd9:  r = i_op(OP_INV, R_T1, R_T1, R_ZERO);
         7'd10: r = i_red(R_T2, SRC_N2, 5'd0);
         7'd11: r = i_op(OP_MUL, R_W, R_T2, R_T1);
         7'd12: r = i_op(OP_ADD, R_UP, R_U, R_ONE);
         7'd13: r = i_op(OP_CHKZ, R_ZERO, R_UP, R_ZERO);
         7'd14: r = i_op(OP_ADD, R_WP, R_W, R_ONE);
         7'd15: r = i_op(OP_CHKZ, R_ZERO, R_WP, R_ZERO);
         7'd16: r = i_op(OP_MUL, R_U2, R_U, R_U);
         7'd17: r = i_op(OP_MUL, R_W2, R_W, R_W);
         7'd18: r = i_op(OP_CHKEQ, R_ZERO, R_U2, R_W2);
         7'd19: r = i_red(R_T0, SRC_IMM, 5'd2);
         7'd20: r = i_op(OP_INV, R_HALF, R_T0, R_ZERO);
         7'd21: r = i_op(OP_MUL, R_T0, R_U2, R_U);
         7'd22: r = i_op(OP_MUL, R_T1, R_T0, R_U2);
         7'd23: r = i_op(OP_SUB, R_T1, R_T0, R_T1);
         7'd24: r = i_op(OP_MUL, R_T2, R_U2, R_HALF);
         7'd25: r = i_op(OP_ADD, R_T1, R_T1, R_T2);
         7'd26: r = i_op(OP_MUL, R_T2, R_UP, R_UP);
         7'd27: r = i_op(OP_INV, R_T2, R_T2, R_ZERO);
         7'd28: r = i_op(OP_MUL, R_G1, R_T1, R_T2);
         7'd29: r = i_op(OP_MUL, R_T0, R_W2, R_W);
         7'd30: r = i_op(OP_MUL, R_T1, R_T0, R_W2);
         7'd31: r = i_op(OP_SUB, R_T1, R_T0, R_T1);
         7'd32: r = i_op(OP_MUL, R_T2, R_W2, R_HALF);
         7'd33: r = i_op(OP_ADD, R_T1, R_T1, R_T2);
         7'd34: r = i_op(OP_MUL, R_T2, R_WP, R_WP);
         7'd35: r = i_op(OP_INV, R_T2, R_T2, R_ZERO);
         7'd36: r = i_op(OP_MUL, R_G2, R_T1, R_T2);
         7'd37: r = i_op(OP_SUB, R_T0, R_G1, R_G2);
         7'd38: r = i_op(OP_SUB, R_T1, R_U2, R_W2);
         7'd39: r = i_op(OP_INV, R_T1, R_T1, R_ZERO);
         7'd40: r = i_op(OP_MUL, R_K4, R_T0, R_T1);
         7'd41: r = i_op(OP_MUL, R_T0, R_K4, R_U2);
         7'd42: r = i_op(OP_SUB, R_K0, R_G1, R_T0);
         7'd43: r = i_op(OP_ADD, R_T0, R_K4, R_K4);
         7'd44: r = i_op(OP_SUB, R_Q3, R_T0, R_ONE);
         7'd45: r = i_op(OP_ADD, R_T0, R_K4, R_K0);
         7'd46: r = i_op(OP_SUB, R_Q2, R_T0, R_HALF);
         7'd47: r = i_op(OP_ADD, R_S1, R_U, R_W);
         7'd48: r = i_op(OP_MUL, R_S2, R_U, R_W);
         7'd49: r = i_op(OP_ADD, R_CA, R_K4, R_S1);
         7'd50: r = i_op(OP_SUB, R_T0, R_Q3, R_S2);
         7'd51: r = i_op(OP_MUL, R_T1, R_S1, R_CA);
         7'd52: r = i_op(OP_ADD, R_CB, R_T0, R_T1);
         7'd53: r = i_op(OP_MUL, R_T0, R_S2, R_CA);
         7'd54: r = i_op(OP_SUB, R_T0, R_Q2, R_T0);
         7'd55: r = i_op(OP_MUL, R_T1, R_S1, R_CB);
         7'd56: r = i_op(OP_ADD, R_CC, R_T0, R_T1);
         7'd57: r = i_op(OP_ADD, R_T0, R_V, R_CA);
         7'd58: r = i_op(OP_MUL, R_T0, R_T0, R_V);
         7'd59: r = i_op(OP_ADD, R_T0, R_T0, R_CB);
         7'd60: r = i_op(OP_MUL, R_T0, R_T0, R_V);
         7'd61: r = i_op(OP_ADD, R_T0, R_T0, R_CC);
         7'd62: r = i_scan(FLG_ROOT, R_T0, R_ZERO, PC_ROOT_LOOP);
         7'd63: r = i_op(OP_MUL, R_T0, R_CA, R_CA);
         7'd64: r = i_op(OP_MUL, R_T1, R_T0, R_CA);
         7'd65: r = i_op(OP_MUL, R_T2, R_CB, R_CB);
         7'd66: r = i_op(OP_MUL, R_T3, R_T2, R_CB);
         7'd67: r = i_red(R_D, SRC_IMM, 5'd18);
         7'd68: r = i_op(OP_MUL, R_D, R_D, R_CA);
         7'd69: r = i_op(OP_MUL, R_D, R_D, R_CB);
         7'd70: r = i_op(OP_MUL, R_D, R_D, R_CC);
         7'd71: r = i_red(R_G1, SRC_IMM, 5'd4);
         7'd72: r = i_op(OP_MUL, R_T1, R_G1, R_T1);
         7'd73: r = i_op(OP_MUL, R_T1, R_T1, R_CC);
         7'd74: r = i_op(OP_SUB, R_D, R_D, R_T1);
         7'd75: r = i_op(OP_MUL, R_T1, R_T0, R_T2);
         7'd76: r = i_op(OP_ADD, R_D, R_D, R_T1);
         7'd77: r = i_op(OP_MUL, R_T3, R_G1, R_T3);
         7'd78: r = i_op(OP_SUB, R_D, R_D, R_T3);
         7'd79: r = i_op(OP_MUL, R_T1, R_CC, R_CC);
         7'd80: r = i_red(R_G2, SRC_IMM, 5'd27);
         7'd81: r = i_op(OP_MUL, R_T1, R_G2, R_T1);
         7'd82: r = i_op(OP_SUB, R_D, R_D, R_T1);
         7'd83: r = i_op(OP_MUL, R_T0, R_V, R_V);
         7'd84: r = i_scan(FLG_SQ, R_T0, R_D, PC_SQ_LOOP);
         default: r = i_op(OP_END, R_ZERO, R_ZERO, R_ZERO);
      endcase
      return r;
   endfunction

endpackage

@@ sv/residual_cubic_root_sieve_mod_p.sv @@
// Top level of the residual cubic root sieve: microcode sequencer, register
// file and a shared shift-and-add modular multiplier. Depends on rcrs_pkg.
`timescale 1ns / 1ps
// A modulus below three skips the program and gives an undefined result.
// Products, input reductions and inverses run through one modular multiplier
// that takes one multiplier bit per cycle; sums and differences bypass it.
// Each of the six inverses is a square and multiply over the bits of p-2.
// The request port stalls for the whole computation, and the result waits in
// an output register so that the next request can be taken while it is still
// pending.
module residual_cubic_root_sieve_mod_p (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rcrs_pkg::HEIGHT_BITS-1:0] req_first_num,
   input  logic [rcrs_pkg::HEIGHT_BITS-2:0]     req_first_den,
   input  logic signed [rcrs_pkg::HEIGHT_BITS-1:0] req_second_num,
   input  logic [rcrs_pkg::HEIGHT_BITS-2:0]     req_second_den,
   input  logic [rcrs_pkg::MODULUS_BITS-1:0]    req_modulus,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_defined,
   output logic [rcrs_pkg::MODULUS_BITS-1:0]    rsp_coef_a,
   output logic [rcrs_pkg::MODULUS_BITS-1:0]    rsp_coef_b,
   output logic [rcrs_pkg::MODULUS_BITS-1:0]    rsp_coef_c,
   output logic                                 rsp_has_root,
   output logic                                 rsp_disc_square
);
   import rcrs_pkg::*;

   localparam int MB = MODULUS_BITS;
   localparam int HB = HEIGHT_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_MDONE = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [HB-1:0]       n1_ff, n1_in, n2_ff, n2_in;
   logic [HB-2:0]       d1_ff, d1_in, d2_ff, d2_in;
   logic [MB-1:0]       p_ff, p_in;
   logic [PC_BITS-1:0]  pc_ff, pc_in;
   logic [MB-1:0]       v_ff, v_in;
   logic [MB-1:0]       acc_ff, acc_in;
   logic [HB-1:0]       mplier_ff, mplier_in;
   logic [MB-1:0]       mcand_ff, mcand_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [MB-1:0]       base_ff, base_in;
   logic [CNT_BITS-1:0] ibit_ff, ibit_in;
   logic                inv_sq_ff, inv_sq_in;
   logic                root_ff, root_in, sq_ff, sq_in, def_ff, def_in;
   logic [MB-1:0]       ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_def_ff, rsp_def_in;
   logic [MB-1:0]       rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in, rsp_c_ff, rsp_c_in;
   logic                rsp_root_ff, rsp_root_in, rsp_sq_ff, rsp_sq_in;

   logic [MB-1:0]       rf_mem [2**RA_BITS];
   logic [MB-1:0]       rd_a_ff, rd_b_ff;
   logic                rf_we;
   logic [RA_BITS-1:0]  rf_wa;
   logic [MB-1:0]       rf_wd;

   instr_type           ins;
   logic [MB-1:0]       opa, opb;
   logic [MB+1:0]       addend, t0, t1, t2, pw2;
   logic [MB:0]         sum, add_fix, sub_fix, p1;
   logic [MB-1:0]       add_res, sub_res, step_res, red_res, expo;
   logic [HB-1:0]       srcv, red_mag;
   logic                red_neg;

   assign ins = ucode(pc_ff);
   assign opa = (ins.sa == R_V) ? v_ff : rd_a_ff;
   assign opb = (ins.sb == R_V) ? v_ff : rd_b_ff;
   assign pw2 = {2'b00, p_ff};
   assign p1  = {1'b0, p_ff};

   assign addend   = mplier_ff[cnt_ff] ? {2'b00, mcand_ff} : '0;
   assign t0       = {1'b0, acc_ff, 1'b0} + addend;
   assign t1       = (t0 >= pw2) ? t0 - pw2 : t0;
   assign t2       = (t1 >= pw2) ? t1 - pw2 : t1;
   assign step_res = t2[MB-1:0];

   assign sum     = {1'b0, opa} + {1'b0, opb};
   assign add_fix = (sum >= p1) ? sum - p1 : sum;
   assign add_res = add_fix[MB-1:0];
   assign sub_fix = (opa >= opb) ? {1'b0, opa} - {1'b0, opb} : {1'b0, opa} + p1 - {1'b0, opb};
   assign sub_res = sub_fix[MB-1:0];

   assign red_res = (neg_ff && (acc_ff != '0)) ? p_ff - acc_ff : acc_ff;
   assign expo    = p_ff - MB'(2);

   always_comb begin
      case (ins.src)
         SRC_N1:  srcv = n1_ff;
         SRC_D1:  srcv = {1'b0, d1_ff};
         SRC_N2:  srcv = n2_ff;
         SRC_D2:  srcv = {1'b0, d2_ff};
         SRC_IMM: srcv = HB'(ins.imm);
         default: srcv = '0;
      endcase
   end
   assign red_neg = srcv[HB-1];
   assign red_mag = red_neg ? (~srcv) + HB'(1) : srcv;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      p_in         = p_ff;
      pc_in        = pc_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      mplier_in    = mplier_ff;
      mcand_in     = mcand_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      ibit_in      = ibit_ff;
      inv_sq_in    = inv_sq_ff;
      root_in      = root_ff;
      sq_in        = sq_ff;
      def_in       = def_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_def_in   = rsp_def_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_c_in     = rsp_c_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_sq_in    = rsp_sq_ff;
      rf_we        = 1'b0;
      rf_wa        = ins.dst;
      rf_wd        = acc_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n1_in   = req_first_num;
               n2_in   = req_second_num;
               d1_in   = req_first_den;
               d2_in   = req_second_den;
               p_in    = req_modulus;
               pc_in   = '0;
               v_in    = '0;
               root_in = 1'b0;
               sq_in   = 1'b0;
               def_in  = 1'b0;
               state_in = (req_modulus < MB'(3)) ? S_OUT : S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (ins.opc)
               OP_RED: begin
                  mplier_in = red_mag;
                  mcand_in  = MB'(1);
                  acc_in    = '0;
                  cnt_in    = CNT_BITS'(HB - 1);
                  neg_in    = red_neg;
                  state_in  = S_MUL;
               end
               OP_MUL: begin
                  mplier_in = HB'(opa);
                  mcand_in  = opb;
                  acc_in    = '0;
                  cnt_in    = CNT_BITS'(MB - 1);
                  state_in  = S_MUL;
               end
               OP_ADD: begin
                  rf_we    = 1'b1;
                  rf_wd    = add_res;
                  pc_in    = pc_ff + PC_BITS'(1);
                  state_in = S_FETCH;
               end
               OP_SUB: begin
                  rf_we    = 1'b1;
                  rf_wd    = sub_res;
                  pc_in    = pc_ff + PC_BITS'(1);
                  state_in = S_FETCH;
               end
               OP_INV: begin
                  base_in   = opa;
                  ibit_in   = CNT_BITS'(MB - 1);
                  inv_sq_in = 1'b1;
                  mplier_in = HB'(1);
                  mcand_in  = MB'(1);
                  acc_in    = '0;
                  cnt_in    = CNT_BITS'(MB - 1);
                  state_in  = S_MUL;
               end
               OP_CHKZ: begin
                  if (opa == '0) begin
                     state_in = S_OUT;
                  end else begin
                     pc_in    = pc_ff + PC_BITS'(1);
                     state_in = S_FETCH;
                  end
               end
               OP_CHKEQ: begin
                  if (opa == opb) begin
                     state_in = S_OUT;
                  end else begin
                     pc_in    = pc_ff + PC_BITS'(1);
                     state_in = S_FETCH;
                  end
               end
               OP_SCAN: begin
                  state_in = S_FETCH;
                  if (opa == opb) begin
                     if (ins.dst == FLG_ROOT) begin
                        root_in = 1'b1;
                     end else begin
                        sq_in = 1'b1;
                     end
                     v_in  = '0;
                     pc_in = pc_ff + PC_BITS'(1);
                  end else if (v_ff + MB'(1) == p_ff) begin
                     v_in  = '0;
                     pc_in = pc_ff + PC_BITS'(1);
                  end else begin
                     v_in  = v_ff + MB'(1);
                     pc_in = ins.tgt;
                  end
               end
               OP_END: begin
                  def_in   = 1'b1;
                  state_in = S_OUT;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_MUL: begin
            acc_in = step_res;
            if (cnt_ff == '0) begin
               state_in = S_MDONE;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         S_MDONE: begin
            case (ins.opc)
               OP_RED: begin
                  rf_we    = 1'b1;
                  rf_wd    = red_res;
                  pc_in    = pc_ff + PC_BITS'(1);
                  state_in = S_FETCH;
               end
               OP_MUL: begin
                  rf_we    = 1'b1;
                  pc_in    = pc_ff + PC_BITS'(1);
                  state_in = S_FETCH;
               end
               OP_INV: begin
                  acc_in = '0;
                  cnt_in = CNT_BITS'(MB - 1);
                  if (inv_sq_ff && expo[ibit_ff]) begin
                     mplier_in = HB'(acc_ff);
                     mcand_in  = base_ff;
                     inv_sq_in = 1'b0;
                     state_in  = S_MUL;
                  end else if (ibit_ff == '0) begin
                     acc_in   = acc_ff;
                     rf_we    = 1'b1;
                     pc_in    = pc_ff + PC_BITS'(1);
                     state_in = S_FETCH;
                  end else begin
                     ibit_in   = ibit_ff - CNT_BITS'(1);
                     mplier_in = HB'(acc_ff);
                     mcand_in  = acc_ff;
                     inv_sq_in = 1'b1;
                     state_in  = S_MUL;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_def_in   = def_ff;
               rsp_a_in     = def_ff ? ca_ff : '0;
               rsp_b_in     = def_ff ? cb_ff : '0;
               rsp_c_in     = def_ff ? cc_ff : '0;
               rsp_root_in  = def_ff && root_ff;
               rsp_sq_in    = def_ff && sq_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ca_in = ca_ff;
      cb_in = cb_ff;
      cc_in = cc_ff;
      if (rf_we && rf_wa == R_CA) begin
         ca_in = rf_wd;
      end
      if (rf_we && rf_wa == R_CB) begin
         cb_in = rf_wd;
      end
      if (rf_we && rf_wa == R_CC) begin
         cc_in = rf_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      if (state_ff == S_FETCH) begin
         rd_a_ff <= rf_mem[ins.sa];
         rd_b_ff <= rf_mem[ins.sb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      p_ff        <= p_in;
      pc_ff       <= pc_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      mplier_ff   <= mplier_in;
      mcand_ff    <= mcand_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      ibit_ff     <= ibit_in;
      inv_sq_ff   <= inv_sq_in;
      root_ff     <= root_in;
      sq_ff       <= sq_in;
      def_ff      <= def_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      cc_ff       <= cc_in;
      rsp_def_ff  <= rsp_def_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_c_ff    <= rsp_c_in;
      rsp_root_ff <= rsp_root_in;
      rsp_sq_ff   <= rsp_sq_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_defined     = rsp_def_ff;
   assign rsp_coef_a      = rsp_a_ff;
   assign rsp_coef_b      = rsp_b_ff;
   assign rsp_coef_c      = rsp_c_ff;
   assign rsp_has_root    = rsp_root_ff;
   assign rsp_disc_square = rsp_sq_ff;

endmodule

@@ sv/rcrs_checker.sv @@
// Port checker for the residual cubic root sieve, bound to the top level.
// Depends on rcrs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "residual_cubic_root_sieve_mod_p_macros.svh"
module rcrs_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_defined,
   input logic [rcrs_pkg::MODULUS_BITS-1:0]    rsp_coef_a,
   input logic [rcrs_pkg::MODULUS_BITS-1:0]    rsp_coef_b,
   input logic [rcrs_pkg::MODULUS_BITS-1:0]    rsp_coef_c,
   input logic                                 rsp_has_root,
   input logic                                 rsp_disc_square
);

   // An undefined result carries no coefficients and no flags.
   `RCRS_ASSERT_NOW(a_undef_zero, clock, reset, rsp_valid && !rsp_defined, rsp_coef_a == '0 && rsp_coef_b == '0 && rsp_coef_c == '0 && !rsp_has_root && !rsp_disc_square)

   // Once a request is taken the block is busy on the next cycle.
   `RCRS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // A fresh result appears only as the sequencer returns to idle.
   `RCRS_ASSERT_NOW(a_idle_with_rsp, clock, reset, $rose(rsp_valid), !req_stall)

   // A stalled result holds.
   `RCRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_coef_a) && $stable(rsp_coef_b) && $stable(rsp_coef_c) && $stable(rsp_defined))

endmodule

bind residual_cubic_root_sieve_mod_p rcrs_checker u_rcrs_checker (.*);

@@ test/residual_cubic_root_sieve_mod_p_checker.sv @@
// Checker for the residual cubic root sieve: watches the request and result
// channels, predicts each result and compares it. Depends on rcrs_pkg.
`timescale 1ns / 1ps
module residual_cubic_root_sieve_mod_p_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [rcrs_pkg::HEIGHT_BITS-1:0] req_first_num,
   input  logic [rcrs_pkg::HEIGHT_BITS-2:0]        req_first_den,
   input  logic signed [rcrs_pkg::HEIGHT_BITS-1:0] req_second_num,
   input  logic [rcrs_pkg::HEIGHT_BITS-2:0]        req_second_den,
   input  logic [rcrs_pkg::MODULUS_BITS-1:0]       req_modulus,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic                                    rsp_defined,
   input  logic [rcrs_pkg::MODULUS_BITS-1:0]       rsp_coef_a,
   input  logic [rcrs_pkg::MODULUS_BITS-1:0]       rsp_coef_b,
   input  logic [rcrs_pkg::MODULUS_BITS-1:0]       rsp_coef_c,
   input  logic                                    rsp_has_root,
   input  logic                                    rsp_disc_square,
   output int                                      fail_count,
   output int                                      pending
);
   typedef struct packed {
      logic                             defined;
      logic [rcrs_pkg::MODULUS_BITS-1:0] coef_a;
      logic [rcrs_pkg::MODULUS_BITS-1:0] coef_b;
      logic [rcrs_pkg::MODULUS_BITS-1:0] coef_c;
      logic                             has_root;
      logic                             disc_square;
   } cubic_type;

   cubic_type cubic_queue[$];

   function automatic longint fold(longint a, longint p);
      longint r;
      r = a % p;
      if (r < 0) r += p;
      return r;
   endfunction

   function automatic longint fermat_inv(longint x, longint p);
      longint r, b, e;
      b = fold(x, p);
      if (b == 0) return 0;
      r = 1 % p;
      e = p - 2;
      while (e > 0) begin
         if (e & 1) r = r * b % p;
         b = b * b % p;
         e >>= 1;
      end
      return r;
   endfunction

   function automatic cubic_type residual_cubic(longint n1, longint d1, longint n2,
                                               longint d2, longint p);
      cubic_type c;
      longint u, w, up, wp, u2, w2, half, u3, u5, w3, w5, g1, g2, k4, k0, q3, q2;
      longint s1, s2, ca, cb, cc, t, a2, a3, b2, b3, c2, d;
      bit root, sq;
      c = '0;
      if (p < 3) return c;
      if (fold(d1, p) == 0 || fold(d2, p) == 0) return c;
      u = fold(n1, p) * fermat_inv(d1, p) % p;
      w = fold(n2, p) * fermat_inv(d2, p) % p;
      up = fold(u + 1, p);
      wp = fold(w + 1, p);
      if (up == 0 || wp == 0) return c;
      u2 = u * u % p;
      w2 = w * w % p;
      if (u2 == w2) return c;
      half = fermat_inv(2, p);
      u3 = u2 * u % p; u5 = u3 * u2 % p;
      w3 = w2 * w % p; w5 = w3 * w2 % p;
      g1 = fold(-u5 + u3 + u2 * half % p, p) * fermat_inv(up * up % p, p) % p;
      g2 = fold(-w5 + w3 + w2 * half % p, p) * fermat_inv(wp * wp % p, p) % p;
      k4 = fold(g1 - g2, p) * fermat_inv(fold(u2 - w2, p), p) % p;
      k0 = fold(g1 - k4 * u2 % p, p);
      q3 = fold(2 * k4 - 1, p);
      q2 = fold(k4 + k0 - half, p);
      s1 = fold(u + w, p);
      s2 = u * w % p;
      ca = fold(k4 + s1, p);
      cb = fold(q3 - s2 + s1 * ca % p, p);
      cc = fold(q2 - s2 * ca % p + s1 * cb % p, p);
      root = 0;
      for (longint v = 0; v < p && !root; v++) begin
         t = (v * v % p * v + ca * v % p * v + cb * v + cc) % p;
         if (t == 0) root = 1;
      end
      a2 = ca * ca % p; a3 = a2 * ca % p;
      b2 = cb * cb % p; b3 = b2 * cb % p; c2 = cc * cc % p;
      d = (18 * ca % p) * cb % p * cc % p;
      d -= (4 * a3 % p) * cc % p;
      d += a2 * b2 % p;
      d -= 4 * b3 % p;
      d -= 27 * c2 % p;
      d = fold(d, p);
      sq = (d == 0);
      for (longint v = 0; v < p && !sq; v++)
         if (v * v % p == d) sq = 1;
      c.defined = 1;
      c.coef_a = ca[rcrs_pkg::MODULUS_BITS-1:0];
      c.coef_b = cb[rcrs_pkg::MODULUS_BITS-1:0];
      c.coef_c = cc[rcrs_pkg::MODULUS_BITS-1:0];
      c.has_root = root;
      c.disc_square = sq;
      return c;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      cubic_type want, got;
      if (!reset) begin
         if (req_valid && !req_stall)
            cubic_queue.push_back(residual_cubic(longint'(req_first_num),
               longint'(req_first_den), longint'(req_second_num),
               longint'(req_second_den), longint'(req_modulus)));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_defined, rsp_coef_a, rsp_coef_b, rsp_coef_c, rsp_has_root,
                   rsp_disc_square};
            if (cubic_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = cubic_queue.pop_front();
               if (want !== got) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected def=%0d a=%0d b=%0d c=%0d root=%0d sq=%0d, actual def=%0d a=%0d b=%0d c=%0d root=%0d sq=%0d",
                        want.defined, want.coef_a, want.coef_b, want.coef_c,
                        want.has_root, want.disc_square, got.defined, got.coef_a,
                        got.coef_b, got.coef_c, got.has_root, got.disc_square);
               end
            end
         end
         pending = cubic_queue.size();
      end
   end
endmodule

@@ test/testbench.sv @@
// Top of the residual cubic root sieve testbench: clock, reset, request
// stimulus and verdict. Depends on rcrs_pkg, the block and the checker.
`timescale 1ns / 1ps
module testbench;
   import rcrs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [HEIGHT_BITS-1:0] req_first_num = '0;
   logic [HEIGHT_BITS-2:0] req_first_den = 15'd1;
   logic signed [HEIGHT_BITS-1:0] req_second_num = '0;
   logic [HEIGHT_BITS-2:0] req_second_den = 15'd1;
   logic [MODULUS_BITS-1:0] req_modulus = 10'd5;
   logic rsp_valid, rsp_stall = 1'b0;
   logic rsp_defined, rsp_has_root, rsp_disc_square;
   logic [MODULUS_BITS-1:0] rsp_coef_a, rsp_coef_b, rsp_coef_c;
   int fail_count, pending, cycles = 0;
   bit hold_off = 1'b0;
   int small_primes[$] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};
   int large_primes[$] = '{1021, 1019, 1013, 997, 509, 257, 127};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   residual_cubic_root_sieve_mod_p dut (.*);

   residual_cubic_root_sieve_mod_p_checker checker_inst (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 40000000) begin
         $display("[residual_cubic_root_sieve_mod_p] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   task automatic send(input logic signed [15:0] n1, input logic [14:0] d1,
                       input logic signed [15:0] n2, input logic [14:0] d2,
                       input logic [9:0] p);
      req_valid <= 1'b1;
      req_first_num <= n1;
      req_first_den <= d1;
      req_second_num <= n2;
      req_second_den <= d2;
      req_modulus <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_request();
      int p, sel;
      logic signed [15:0] n1, n2;
      logic [14:0] d1, d2;
      sel = $urandom_range(0, 19);
      if (sel == 0) p = large_primes[$urandom_range(0, large_primes.size() - 1)];
      else if (sel == 1) p = $urandom_range(0, 1023);
      else p = small_primes[$urandom_range(0, small_primes.size() - 1)];
      n1 = 16'($urandom); n2 = 16'($urandom);
      d1 = 15'($urandom); d2 = 15'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         n1 = 16'($signed($urandom_range(0, 200)) - 100);
         n2 = 16'($signed($urandom_range(0, 200)) - 100);
         d1 = 15'($urandom_range(1, 20));
         d2 = 15'($urandom_range(1, 20));
      end
      send(n1, d1, n2, d2, p[9:0]);
   endtask

   initial begin
      int gap;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(16'sd2, 15'd1, 16'sd3, 15'd1, 10'd7);
      send(16'sd32767, 15'd32767, -16'sd32767, 15'd1, 10'd1021);
      send(-16'sd32768, 15'd1, 16'sd32767, 15'd32767, 10'd1019);
      send(16'sd1, 15'd0, 16'sd2, 15'd3, 10'd11);
      send(16'sd1, 15'd3, 16'sd2, 15'd0, 10'd11);
      send(16'sd1, 15'd13, 16'sd2, 15'd3, 10'd13);
      send(-16'sd1, 15'd1, 16'sd2, 15'd1, 10'd11);
      send(16'sd2, 15'd1, -16'sd1, 15'd1, 10'd11);
      send(16'sd3, 15'd1, -16'sd3, 15'd1, 10'd11);
      send(16'sd3, 15'd1, 16'sd3, 15'd1, 10'd11);
      send(16'sd1, 15'd1, 16'sd2, 15'd1, 10'd0);
      send(16'sd1, 15'd1, 16'sd2, 15'd1, 10'd1);
      send(16'sd1, 15'd1, 16'sd2, 15'd1, 10'd2);
      send(16'sd1, 15'd1, 16'sd2, 15'd1, 10'd3);
      send(16'sd1, 15'd1, 16'sd2, 15'd1, 10'd4);
      send(16'sd1, 15'd1, 16'sd3, 15'd1, 10'd9);
      send(16'sd5, 15'd7, 16'sd4, 15'd9, 10'd1023);
      send(16'sd0, 15'd5, 16'sd1, 15'd2, 10'd5);
      send(16'sd21845, 15'd10922, -16'sd21846, 15'd21845, 10'd682);
      hold_off <= 1'b1;
      fork
         begin
            repeat (30000) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      for (int i = 0; i < 4; i++) random_request();
      req_valid <= 1'b0;
      for (int i = 0; i < 117; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge clock);
         end
         random_request();
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("[residual_cubic_root_sieve_mod_p] OK");
      else
         $display("[residual_cubic_root_sieve_mod_p] ERROR");
      $finish;
   end
endmodule
